[hw/rtl/bfbp_pkg.sv]
package bfbp_pkg;

   localparam int ENTRIES_DEF = 16;

   localparam int SIZE_W     = 32;
   localparam int REL_W      = 4;
   localparam int OUT_IDX_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [SIZE_W-1:0] MAX_BUFFER_SIZE_RST = 32'd65536;
   localparam logic [SIZE_W-1:0] MAX_SLACK_RST       = 32'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_ENABLED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUFFER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SLACK       = 2'd2;

   typedef enum logic {
      REQ_ACQUIRE = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_FIT       = 3'd0,
      STAT_GROWN     = 3'd1,
      STAT_APPENDED  = 3'd2,
      STAT_REPLACED  = 3'd3,
      STAT_UNTRACKED = 3'd4,
      STAT_BYPASS    = 3'd5,
      STAT_RELEASED  = 3'd6,
      STAT_IGNORED   = 3'd7
   } status_type;

   typedef struct packed {
      logic clear;
      logic eval;
      logic busy;
   } scan_ctl_type;

   typedef struct packed {
      logic have_fit;
      logic have_small;
      logic have_large;
   } scan_flags_type;

endpackage

[hw/rtl/bfbp_ram.sv]
module bfbp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bfbp_scan.sv]
module bfbp_scan #(
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfbp_pkg::scan_ctl_type      ctl,
   input  logic [bfbp_pkg::SIZE_W-1:0] entry_data,
   input  logic [IDX_W-1:0]            entry_idx,
   input  logic [bfbp_pkg::SIZE_W-1:0] req_size,
   input  logic [bfbp_pkg::SIZE_W-1:0] max_slack,
   output bfbp_pkg::scan_flags_type    flags,
   output logic [IDX_W-1:0]            fit_idx,
   output logic [bfbp_pkg::SIZE_W-1:0] fit_size,
   output logic [IDX_W-1:0]            small_idx,
   output logic [IDX_W-1:0]            large_idx
);

   bfbp_pkg::scan_flags_type    flags_ff, flags_in;
   logic [IDX_W-1:0]            fit_idx_ff, fit_idx_in;
   logic [IDX_W-1:0]            small_idx_ff, small_idx_in;
   logic [IDX_W-1:0]            large_idx_ff, large_idx_in;
   logic [bfbp_pkg::SIZE_W-1:0] fit_size_ff, fit_size_in;
   logic [bfbp_pkg::SIZE_W-1:0] small_size_ff, small_size_in;
   logic [bfbp_pkg::SIZE_W-1:0] diff;
   logic                        is_small;
   logic                        is_large;
   logic                        free_eval;

   always_comb begin
      free_eval     = ctl.eval && !ctl.busy;
      is_small      = entry_data < req_size;
      diff          = entry_data - req_size;
      is_large      = !is_small && (diff > max_slack);
      flags_in      = flags_ff;
      fit_idx_in    = fit_idx_ff;
      fit_size_in   = fit_size_ff;
      small_idx_in  = small_idx_ff;
      small_size_in = small_size_ff;
      large_idx_in  = large_idx_ff;
      if (ctl.clear) begin
         flags_in = '0;
      end else if (free_eval) begin
         if (is_small) begin
            if (!flags_ff.have_small || entry_data > small_size_ff) begin
               flags_in.have_small = 1'b1;
               small_idx_in        = entry_idx;
               small_size_in       = entry_data;
            end
         end else if (is_large) begin
            flags_in.have_large = 1'b1;
            large_idx_in        = entry_idx;
         end else if (!flags_ff.have_fit || entry_data < fit_size_ff) begin
            flags_in.have_fit = 1'b1;
            fit_idx_in        = entry_idx;
            fit_size_in       = entry_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      fit_idx_ff    <= fit_idx_in;
      fit_size_ff   <= fit_size_in;
      small_idx_ff  <= small_idx_in;
      small_size_ff <= small_size_in;
      large_idx_ff  <= large_idx_in;
   end

   assign flags     = flags_ff;
   assign fit_idx   = fit_idx_ff;
   assign fit_size  = fit_size_ff;
   assign small_idx = small_idx_ff;
   assign large_idx = large_idx_ff;

endmodule

[hw/rtl/best_fit_buffer_pool_top.sv]
// Best-fit buffer pool allocator.
// Request channel (req_): one item per acquire or release. req_tuser is the kind
// (acquire or release), req_tdata carries the requested size and the release index.
// Response channel (rsp_): exactly one item per request. rsp_tuser is the status,
// rsp_tdata carries the granted entry index and the buffer size.
// Configuration channel (csr_): always ready, one register write per item.
// A release or a bypassed acquire skips the scan: its result is registered and then
// loaded into the output register. A pooled acquire scans the records one per cycle
// through the size memory read port and then picks its result in ST_DECIDE.
// One request is in flight at a time; req_tready is low from acceptance until the
// response is loaded into the output register. The next request is taken while
// that response still waits for rsp_tready.
// A stalled response holds rsp_tvalid and its payload; a finished request then
// waits until the output register frees up.
// Reset clears all busy marks and the record count, restores the register
// defaults (pool enabled, 65536 byte limit, 4096 byte slack) and drops any
// pending response.
module best_fit_buffer_pool_top #(
   parameter int ENTRIES = bfbp_pkg::ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfbp_pkg::REQ_DATA_W-1:0] req_tdata,   // req_size, release_index, pad
   input  logic                            req_tuser,   // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfbp_pkg::RSP_DATA_W-1:0] rsp_tdata,   // entry_index, buffer_size, pad
   output logic [2:0]                      rsp_tuser,   // status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfbp_pkg::SIZE_W-1:0]     csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SW    = bfbp_pkg::SIZE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_OUT
   } state_type;

   state_type                        state_ff, state_in;
   logic [SW-1:0]                    req_size_ff, req_size_in;
   logic [CNT_W-1:0]                 ptr_ff, ptr_in;
   logic                             ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]                 ev_idx_ff, ev_idx_in;
   bfbp_pkg::status_type             res_status_ff, res_status_in;
   logic [bfbp_pkg::OUT_IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [SW-1:0]                    res_size_ff, res_size_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bfbp_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [bfbp_pkg::OUT_IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [SW-1:0]                    rsp_size_ff, rsp_size_in;
   logic [ENTRIES-1:0]               busy_ff, busy_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             pool_en_ff, pool_en_in;
   logic [SW-1:0]                    max_size_ff, max_size_in;
   logic [SW-1:0]                    max_slack_ff, max_slack_in;

   logic                             ram_we;
   logic [IDX_W-1:0]                 ram_waddr;
   logic [SW-1:0]                    ram_rdata;
   bfbp_pkg::scan_ctl_type           scan_ctl;
   bfbp_pkg::scan_flags_type         scan_flags;
   logic [IDX_W-1:0]                 fit_idx;
   logic [SW-1:0]                    fit_size;
   logic [IDX_W-1:0]                 small_idx;
   logic [IDX_W-1:0]                 large_idx;

   logic [SW-1:0]                    in_size;
   logic [bfbp_pkg::REL_W-1:0]       in_rel;
   logic                             rel_ok;
   logic                             issue;

   assign in_size = req_tdata[SW-1:0];
   assign in_rel  = req_tdata[SW+bfbp_pkg::REL_W-1:SW];
   assign rel_ok  = (32'(in_rel) < 32'(count_ff)) && busy_ff[IDX_W'(in_rel)];
   assign issue   = ptr_ff < count_ff;

   bfbp_ram #(
      .WIDTH (SW),
      .DEPTH (ENTRIES)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_size_ff),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   bfbp_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .entry_data (ram_rdata),
      .entry_idx  (ev_idx_ff),
      .req_size   (req_size_ff),
      .max_slack  (max_slack_ff),
      .flags      (scan_flags),
      .fit_idx    (fit_idx),
      .fit_size   (fit_size),
      .small_idx  (small_idx),
      .large_idx  (large_idx)
   );

   always_comb begin
      state_in      = state_ff;
      req_size_in   = req_size_ff;
      ptr_in        = ptr_ff;
      ev_valid_in   = 1'b0;
      ev_idx_in     = ev_idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_size_in   = rsp_size_ff;
      busy_in       = busy_ff;
      count_in      = count_ff;
      pool_en_in    = pool_en_ff;
      max_size_in   = max_size_ff;
      max_slack_in  = max_slack_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      scan_ctl      = '0;
      scan_ctl.eval = ev_valid_ff;
      scan_ctl.busy = busy_ff[ev_idx_ff];

      if (csr_valid) begin
         case (csr_index)
            bfbp_pkg::CSR_POOL_ENABLED:    pool_en_in   = csr_data[0];
            bfbp_pkg::CSR_MAX_BUFFER_SIZE: max_size_in  = csr_data;
            bfbp_pkg::CSR_MAX_SLACK:       max_slack_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_size_in    = in_size;
               ptr_in         = '0;
               scan_ctl.clear = 1'b1;
               state_in       = ST_OUT;
               if (req_tuser == bfbp_pkg::REQ_RELEASE) begin
                  res_size_in = '0;
                  if (rel_ok) begin
                     busy_in[IDX_W'(in_rel)] = 1'b0;
                     res_status_in           = bfbp_pkg::STAT_RELEASED;
                     res_idx_in              = in_rel;
                  end else begin
                     res_status_in = bfbp_pkg::STAT_IGNORED;
                     res_idx_in    = '0;
                  end
               end else if (!pool_en_ff || in_size > max_size_ff) begin
                  res_status_in = bfbp_pkg::STAT_BYPASS;
                  res_idx_in    = '0;
                  res_size_in   = in_size;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ev_valid_in = issue;
            ev_idx_in   = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end else if (!ev_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in    = ST_OUT;
            res_size_in = req_size_ff;
            if (scan_flags.have_fit) begin
               busy_in[fit_idx] = 1'b1;
               res_status_in    = bfbp_pkg::STAT_FIT;
               res_idx_in       = bfbp_pkg::OUT_IDX_W'(fit_idx);
               res_size_in      = fit_size;
            end else if (scan_flags.have_small) begin
               busy_in[small_idx] = 1'b1;
               ram_we             = 1'b1;
               ram_waddr          = small_idx;
               res_status_in      = bfbp_pkg::STAT_GROWN;
               res_idx_in         = bfbp_pkg::OUT_IDX_W'(small_idx);
            end else if (count_ff < CNT_W'(ENTRIES)) begin
               busy_in[count_ff[IDX_W-1:0]] = 1'b1;
               ram_we                       = 1'b1;
               ram_waddr                    = count_ff[IDX_W-1:0];
               count_in                     = count_ff + CNT_W'(1);
               res_status_in                = bfbp_pkg::STAT_APPENDED;
               res_idx_in                   = bfbp_pkg::OUT_IDX_W'(count_ff);
            end else if (scan_flags.have_large) begin
               busy_in[large_idx] = 1'b1;
               ram_we             = 1'b1;
               ram_waddr          = large_idx;
               res_status_in      = bfbp_pkg::STAT_REPLACED;
               res_idx_in         = bfbp_pkg::OUT_IDX_W'(large_idx);
            end else begin
               res_status_in = bfbp_pkg::STAT_UNTRACKED;
               res_idx_in    = '0;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_size_in   = res_size_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         count_ff     <= '0;
         pool_en_ff   <= 1'b1;
         max_size_ff  <= bfbp_pkg::MAX_BUFFER_SIZE_RST;
         max_slack_ff <= bfbp_pkg::MAX_SLACK_RST;
      end else begin
         state_ff     <= state_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         pool_en_ff   <= pool_en_in;
         max_size_ff  <= max_size_in;
         max_slack_ff <= max_slack_in;
      end
      req_size_ff   <= req_size_in;
      ptr_ff        <= ptr_in;
      ev_idx_ff     <= ev_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(bfbp_pkg::RSP_DATA_W - SW - bfbp_pkg::OUT_IDX_W)'(0),
                        rsp_size_ff, rsp_idx_ff};

endmodule

[hw/rtl/bfbp_checker.sv]
module bfbp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                      rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_no_size_on_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bfbp_pkg::STAT_RELEASED ||
                     rsp_tuser == bfbp_pkg::STAT_IGNORED) |-> rsp_tdata[35:4] == '0)
      else $error("release response carries a buffer size");

   a_no_index_untracked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bfbp_pkg::STAT_UNTRACKED ||
                     rsp_tuser == bfbp_pkg::STAT_BYPASS ||
                     rsp_tuser == bfbp_pkg::STAT_IGNORED) |-> rsp_tdata[3:0] == '0)
      else $error("response without pool entry carries an index");

endmodule

bind best_fit_buffer_pool_top bfbp_checker u_bfbp_checker (.*);

[tb/best_fit_buffer_pool_top_tb.sv]
module best_fit_buffer_pool_top_tb;
   import bfbp_pkg::*;

   localparam int ENTRIES         = ENTRIES_DEF;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct packed {
      status_type           status;
      logic [OUT_IDX_W-1:0] index;
      logic [SIZE_W-1:0]    size;
   } grant_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // req_size, release_index, pad
   logic                  req_tuser  = 1'b0; // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // entry_index, buffer_size, pad
   logic [2:0]            rsp_tuser;         // status
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIZE_W-1:0]     csr_data   = '0;

   logic              pool_on;
   logic [SIZE_W-1:0] size_limit;
   logic [SIZE_W-1:0] slack_limit;
   logic [SIZE_W-1:0] rec_size [ENTRIES];
   logic              rec_busy [ENTRIES];
   int unsigned       rec_count;

   grant_type   expected_grants [$];
   int unsigned mismatches;
   int unsigned sent_items;
   int unsigned seen_items;
   int unsigned status_hits [8];
   int unsigned burst_left;
   bit          gaps_on;
   bit          hold_rsp;

   best_fit_buffer_pool_top #(.ENTRIES(ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic grant_type serve_request(req_kind_type kind, logic [SIZE_W-1:0] size,
                                               logic [REL_W-1:0] rel);
      grant_type         g;
      logic [SIZE_W-1:0] es;
      int                fit_i, short_i, over_i;
      bit                have_fit, have_short, have_over;
      g.status   = STAT_IGNORED;
      g.index    = '0;
      g.size     = '0;
      fit_i      = 0;
      short_i    = 0;
      over_i     = 0;
      have_fit   = 1'b0;
      have_short = 1'b0;
      have_over  = 1'b0;
      if (kind == REQ_RELEASE) begin
         if (rel < rec_count && rec_busy[rel]) begin
            rec_busy[rel] = 1'b0;
            g.status      = STAT_RELEASED;
            g.index       = rel;
         end
         return g;
      end
      g.size = size;
      if (!pool_on || size > size_limit) begin
         g.status = STAT_BYPASS;
         return g;
      end
      for (int i = 0; i < rec_count; i++) begin
         es = rec_size[i];
         if (!rec_busy[i]) begin
            if (es < size) begin
               if (!have_short || es > rec_size[short_i]) begin
                  short_i    = i;
                  have_short = 1'b1;
               end
            end else if (es - size > slack_limit) begin
               over_i    = i;
               have_over = 1'b1;
            end else if (!have_fit || es < rec_size[fit_i]) begin
               fit_i    = i;
               have_fit = 1'b1;
            end
         end
      end
      if (have_fit) begin
         rec_busy[fit_i] = 1'b1;
         g.status        = STAT_FIT;
         g.index         = OUT_IDX_W'(fit_i);
         g.size          = rec_size[fit_i];
      end else if (have_short) begin
         rec_busy[short_i] = 1'b1;
         rec_size[short_i] = size;
         g.status          = STAT_GROWN;
         g.index           = OUT_IDX_W'(short_i);
      end else if (rec_count < ENTRIES) begin
         rec_size[rec_count] = size;
         rec_busy[rec_count] = 1'b1;
         g.status            = STAT_APPENDED;
         g.index             = OUT_IDX_W'(rec_count);
         rec_count++;
      end else if (have_over) begin
         rec_size[over_i] = size;
         rec_busy[over_i] = 1'b1;
         g.status         = STAT_REPLACED;
         g.index          = OUT_IDX_W'(over_i);
      end else begin
         g.status = STAT_UNTRACKED;
      end
      return g;
   endfunction

   task automatic send_request(req_kind_type kind, logic [SIZE_W-1:0] size,
                               logic [REL_W-1:0] rel);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W-SIZE_W-REL_W){1'b0}}, rel, size};
      do @(posedge clock); while (!req_tready);
      expected_grants.insert(expected_grants.size(), serve_request(kind, size, rel));
      sent_items++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(logic enable, logic [SIZE_W-1:0] limit, logic [SIZE_W-1:0] slack);
      logic [CSR_IDX_W-1:0] regs  [3];
      logic [SIZE_W-1:0]    value [3];
      regs[0]  = CSR_POOL_ENABLED;
      regs[1]  = CSR_MAX_BUFFER_SIZE;
      regs[2]  = CSR_MAX_SLACK;
      value[0] = {{(SIZE_W-1){1'b0}}, enable};
      value[1] = limit;
      value[2] = slack;
      wait_idle();
      for (int r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[r];
         csr_data  <= value[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid   <= 1'b0;
      pool_on     = enable;
      size_limit  = limit;
      slack_limit = slack;
   endtask

   task automatic run_traffic(int unsigned count);
      logic [SIZE_W-1:0] size;
      logic [REL_W-1:0]  rel;
      int unsigned       busy_list [$];
      int unsigned       pick, lim;
      repeat (count) begin
         if ($urandom_range(0, 99) < 35) begin
            busy_list.delete();
            for (int i = 0; i < rec_count; i++)
               if (rec_busy[i]) busy_list.insert(busy_list.size(), i);
            if (busy_list.size() != 0 && $urandom_range(0, 99) < 85)
               rel = REL_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            else
               rel = REL_W'($urandom);
            send_request(REQ_RELEASE, SIZE_W'($urandom), rel);
         end else begin
            pick = $urandom_range(0, 9);
            lim  = (slack_limit > 8192) ? 8192 : slack_limit;
            case (pick)
               0, 1, 2, 3: size = $urandom_range(1, 32) * 2048;
               4, 5: begin
                  if (rec_count == 0)
                     size = $urandom_range(0, 4096);
                  else
                     size = rec_size[$urandom_range(0, rec_count - 1)]
                            + $urandom_range(0, 2 * lim) - lim;
               end
               6: size = size_limit + $urandom_range(0, 2) - 1;
               7: size = $urandom;
               default: size = $urandom_range(0, 255);
            endcase
            send_request(REQ_ACQUIRE, size, REL_W'($urandom));
         end
      end
   endtask

   task automatic test_basics();
      gaps_on = 1'b1;
      send_request(REQ_ACQUIRE, '0, '0);
      send_request(REQ_ACQUIRE, MAX_BUFFER_SIZE_RST, '1);
      send_request(REQ_ACQUIRE, MAX_BUFFER_SIZE_RST + 1, '0);
      send_request(REQ_ACQUIRE, '1, '1);
      send_request(REQ_RELEASE, '1, 4'd0);
      send_request(REQ_RELEASE, '0, 4'd0);
      send_request(REQ_RELEASE, '0, 4'd15);
      send_request(REQ_ACQUIRE, 100, '0);
      send_request(REQ_RELEASE, '0, 4'd1);
      send_request(REQ_ACQUIRE, MAX_BUFFER_SIZE_RST - MAX_SLACK_RST, '0);
      send_request(REQ_RELEASE, '0, 4'd1);
      send_request(REQ_ACQUIRE, MAX_BUFFER_SIZE_RST - MAX_SLACK_RST - 1, '0);
      send_request(REQ_ACQUIRE, 300, '0);
      send_request(REQ_ACQUIRE, 300, '0);
      send_request(REQ_RELEASE, '0, 4'd3);
      send_request(REQ_RELEASE, '0, 4'd4);
      send_request(REQ_ACQUIRE, 250, '0);
      send_request(REQ_ACQUIRE, 400, '0);
      send_request(REQ_RELEASE, '0, 4'd2);
   endtask

   task automatic test_full_pool();
      while (rec_count < ENTRIES) send_request(REQ_ACQUIRE, $urandom_range(1000, 20000), '0);
      send_request(REQ_ACQUIRE, 500, '0);
      send_request(REQ_ACQUIRE, 500, '0);
      send_request(REQ_ACQUIRE, 123, '0);
      send_request(REQ_RELEASE, '0, 4'd15);
   endtask

   task automatic test_default_traffic();
      gaps_on = 1'b1;
      run_traffic(260);
   endtask

   task automatic test_tight_slack();
      set_config(1'b1, MAX_BUFFER_SIZE_RST, '0);
      gaps_on = 1'b0;
      run_traffic(140);
   endtask

   task automatic test_wide_open();
      set_config(1'b1, '1, '1);
      gaps_on = 1'b1;
      run_traffic(160);
   endtask

   task automatic test_pool_disabled();
      set_config(1'b0, '1, MAX_SLACK_RST);
      run_traffic(60);
   endtask

   task automatic test_zero_limit();
      set_config(1'b1, '0, MAX_SLACK_RST);
      gaps_on = 1'b0;
      run_traffic(80);
   endtask

   task automatic test_backpressure();
      set_config(1'b1, MAX_BUFFER_SIZE_RST, MAX_SLACK_RST);
      hold_rsp = 1'b1;
      run_traffic(200);
   endtask

   initial begin : rsp_pacing
      int unsigned mode, span, hold_left;
      mode      = 0;
      span      = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_rsp) begin
            hold_left  = RSP_HOLD_CYCLES;
            hold_rsp   = 1'b0;
            rsp_tready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(10, 120);
            end
            span--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_items++;
         if (expected_grants.size() == 0) begin
            $error("unexpected response item: status %0d", rsp_tuser);
            mismatches++;
         end else begin
            want = expected_grants.pop_front();
            status_hits[want.status]++;
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[OUT_IDX_W-1:0] !== want.index) begin
               $error("entry_index: expected %0d, got %0d", want.index,
                      rsp_tdata[OUT_IDX_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[OUT_IDX_W +: SIZE_W] !== want.size) begin
               $error("buffer_size: expected %0d, got %0d", want.size,
                      rsp_tdata[OUT_IDX_W +: SIZE_W]);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("best_fit_buffer_pool_top test failed");
      $finish;
   end

   initial begin : stimulus
      pool_on     = 1'b1;
      size_limit  = MAX_BUFFER_SIZE_RST;
      slack_limit = MAX_SLACK_RST;
      rec_count   = 0;
      foreach (rec_busy[i]) begin
         rec_busy[i] = 1'b0;
         rec_size[i] = '0;
      end
      mismatches = 0;
      sent_items = 0;
      seen_items = 0;
      burst_left = 0;
      gaps_on    = 1'b0;
      hold_rsp   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basics();
      test_full_pool();
      test_default_traffic();
      test_tight_slack();
      test_wide_open();
      test_pool_disabled();
      test_zero_limit();
      test_backpressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               sent_items, seen_items, mismatches);
      $display("fit %0d, grown %0d, appended %0d, replaced %0d, untracked %0d, %s",
               status_hits[STAT_FIT], status_hits[STAT_GROWN], status_hits[STAT_APPENDED],
               status_hits[STAT_REPLACED], status_hits[STAT_UNTRACKED],
               $sformatf("bypass %0d, released %0d, ignored %0d", status_hits[STAT_BYPASS],
                         status_hits[STAT_RELEASED], status_hits[STAT_IGNORED]));
      if (mismatches == 0)
         $display("best_fit_buffer_pool_top test passed");
      else
         $display("best_fit_buffer_pool_top test failed");
      $finish;
   end

endmodule
